[sv/max_heap_priority_queue_top_defines.svh]
// Assertion macros for the port-level checker of the heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Concurrent assertion, masked while reset is high.
`define MHPQ_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("heap queue assertion failed");

// Concurrent assertion that also holds across reset.
`define MHPQ_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("heap queue assertion failed");

`endif

[sv/mhpq_pkg.sv]
// Package for the heap priority queue: widths, codes and controller states.
package mhpq_pkg;

   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 11;
   localparam int STATUS_W     = 2;
   localparam int DEF_CAPACITY = 1024;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_CMP,
      S_RM_LOAD,
      S_DN_RD_L,
      S_DN_RD_R,
      S_DN_CMP
   } state_type;

endpackage

[sv/max_heap_priority_queue_top.sv]
// Binary max-heap priority queue kept in one synchronous single-port-read memory.
// A full insert or an empty remove answers from idle; an insert moves the new value up toward
// the root level by level, and a remove sinks the last entry from the root toward a leaf.
// One transaction at a time, the next accepted as the result shows; no receiver stall.
// Synchronous active-high reset empties the heap; memory contents are not cleared.
module max_heap_priority_queue_top #(
   parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic signed [mhpq_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [mhpq_pkg::DATA_W-1:0]  rsp_removed_value,
   output logic [mhpq_pkg::COUNT_W-1:0]        rsp_count,
   output logic signed [mhpq_pkg::DATA_W-1:0]  rsp_top_value
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;

   // heap storage
   logic signed [DATA_W-1:0] heap_mem [CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;

   // control and datapath registers
   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] lval_ff, lval_in;
   logic                     hasr_ff, hasr_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;
   logic signed [DATA_W-1:0] top_ff;

   // response registers
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_removed_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic signed [DATA_W-1:0] rsp_top_ff;

   // memory port controls
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_data;

   logic                     done;
   status_type               status_now;
   logic signed [DATA_W-1:0] top_now;
   logic [AW-1:0]            parent_idx;
   logic [LW-1:0]            left_idx;
   logic [LW-1:0]            right_idx;
   logic [LW-1:0]            count_ext;
   logic [CW-1:0]            last_idx;

   // index arithmetic for the tree walk
   always_comb begin
      parent_idx = AW'((pos_ff - 1'b1) >> 1);
      left_idx   = {1'b0, pos_ff, 1'b1};
      right_idx  = left_idx + 1'b1;
      count_ext  = LW'(count_ff);
      last_idx   = count_ff - 1'b1;
   end

   // next state, memory port and datapath control
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      lval_in    = lval_ff;
      hasr_in    = hasr_ff;
      removed_in = removed_ff;
      rd_en      = 1'b0;
      rd_addr    = pos_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = val_ff;
      done       = 1'b0;
      status_now = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (action_type'(req_action) == ACT_INSERT) begin
                  removed_in = '0;
                  if (count_ff == CW'(CAPACITY)) begin
                     done       = 1'b1;
                     status_now = ST_FULL;
                  end else begin
                     val_in   = req_value;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                     state_in = S_UP_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     done       = 1'b1;
                     status_now = ST_EMPTY;
                     removed_in = '0;
                  end else begin
                     removed_in = top_ff;
                     count_in   = last_idx;
                     rd_en      = 1'b1;
                     rd_addr    = last_idx[AW-1:0];
                     state_in   = S_RM_LOAD;
                  end
               end
            end
         end
         // sift up: hole at pos, new value waits in val_ff
         S_UP_READ: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               done  = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent_idx;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (val_ff >= rdata_ff) begin
               wr_data  = rdata_ff;
               pos_in   = parent_idx;
               state_in = S_UP_READ;
            end else begin
               done = 1'b1;
            end
         end
         // last entry arrives; it sinks from the root
         S_RM_LOAD: begin
            if (count_ff == '0) begin
               done = 1'b1;
            end else begin
               val_in   = rdata_ff;
               pos_in   = '0;
               state_in = S_DN_RD_L;
            end
         end
         S_DN_RD_L: begin
            if (left_idx >= count_ext) begin
               wr_en = 1'b1;
               done  = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_idx[AW-1:0];
               state_in = S_DN_RD_R;
            end
         end
         S_DN_RD_R: begin
            lval_in  = rdata_ff;
            hasr_in  = (right_idx < count_ext);
            rd_en    = (right_idx < count_ext);
            rd_addr  = right_idx[AW-1:0];
            state_in = S_DN_CMP;
         end
         // left child wins ties; right only when it exists
         S_DN_CMP: begin
            wr_en = 1'b1;
            if ((lval_ff >= val_ff) && (!hasr_ff || (lval_ff >= rdata_ff))) begin
               wr_data  = lval_ff;
               pos_in   = left_idx[AW-1:0];
               state_in = S_DN_RD_L;
            end else if (hasr_ff && (rdata_ff >= val_ff) && (rdata_ff >= lval_ff)) begin
               wr_data  = rdata_ff;
               pos_in   = right_idx[AW-1:0];
               state_in = S_DN_RD_L;
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (done) begin
         state_in = S_IDLE;
      end
   end

   // root value as it stands after this cycle's write
   always_comb begin
      top_now = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;
   end

   // memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= heap_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= done;
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      lval_ff    <= lval_in;
      hasr_ff    <= hasr_in;
      removed_ff <= removed_in;
      top_ff     <= top_now;
      if (done) begin
         rsp_status_ff  <= status_now;
         rsp_removed_ff <= removed_in;
         rsp_count_ff   <= COUNT_W'(count_in);
         rsp_top_ff     <= (count_in == '0) ? '0 : top_now;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_top_value     = rsp_top_ff;

endmodule

[sv/mhpq_checker.sv]
// Port-level checker for the heap priority queue, bound to the top level.
`include "max_heap_priority_queue_top_defines.svh"

module mhpq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_action,
   input logic signed [mhpq_pkg::DATA_W-1:0]  req_value,
   input logic                                rsp_valid,
   input logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [mhpq_pkg::DATA_W-1:0]  rsp_removed_value,
   input logic [mhpq_pkg::COUNT_W-1:0]        rsp_count,
   input logic signed [mhpq_pkg::DATA_W-1:0]  rsp_top_value
);
   import mhpq_pkg::*;

   // an accepted transaction either keeps the block busy or answers at once
   `MHPQ_ASSERT(a_accept_progress, (start && !busy) |=> (busy || rsp_valid))

   // a result only follows an accepted or running transaction
   `MHPQ_ASSERT(a_rsp_has_cause, rsp_valid |-> ($past(start && !busy) || $past(busy)))

   // finishing a walk always delivers its result
   `MHPQ_ASSERT(a_finish_responds, ($fell(busy) && !$past(reset)) |-> rsp_valid)

   // empty remove reports an empty heap and nothing removed
   `MHPQ_ASSERT(a_empty_result, (rsp_valid && (rsp_status == ST_EMPTY)) |->
      ((rsp_count == '0) && (rsp_top_value == '0) && (rsp_removed_value == '0)))

   // an empty heap never reports a maximum
   `MHPQ_ASSERT(a_empty_top, (rsp_valid && (rsp_count == '0)) |-> (rsp_top_value == '0))

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (.*);

[tb/sv/max_heap_priority_queue_checker.sv]
// Checker for the heap priority queue: mirrors the heap and compares every result.
module max_heap_priority_queue_checker #(
   parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                req_action,
   input  logic signed [mhpq_pkg::DATA_W-1:0]  req_value,
   input  logic                                rsp_valid,
   input  logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
   input  logic signed [mhpq_pkg::DATA_W-1:0]  rsp_removed_value,
   input  logic [mhpq_pkg::COUNT_W-1:0]        rsp_count,
   input  logic signed [mhpq_pkg::DATA_W-1:0]  rsp_top_value,
   output int                                  error_count,
   output int                                  open_count
);
   import mhpq_pkg::*;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  removed;
      logic [COUNT_W-1:0]        count;
      logic signed [DATA_W-1:0]  top;
   } heap_result_type;

   // Mirror of the heap contents and its occupancy
   logic signed [DATA_W-1:0] shadow_heap [CAPACITY];
   int                       shadow_size = 0;
   heap_result_type          awaited_results [$];
   int                       mismatch_tally = 0;

   // Apply one transaction to the mirror and return the result it should give
   function automatic heap_result_type apply_heap_op(action_type op,
                                                     logic signed [DATA_W-1:0] val);
      heap_result_type          res;
      int                       pos;
      int                       parent;
      int                       lchild;
      int                       rchild;
      bit                       moving;
      logic signed [DATA_W-1:0] tmp;
      res.status  = ST_OK;
      res.removed = '0;
      if (op == ACT_INSERT) begin
         if (shadow_size >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // append, then move up while the parent is not greater
            shadow_heap[shadow_size] = val;
            pos = shadow_size;
            shadow_size++;
            moving = 1'b1;
            while (moving && pos > 0) begin
               parent = (pos - 1) / 2;
               if (shadow_heap[pos] >= shadow_heap[parent]) begin
                  tmp                 = shadow_heap[pos];
                  shadow_heap[pos]    = shadow_heap[parent];
                  shadow_heap[parent] = tmp;
                  pos                 = parent;
               end else begin
                  moving = 1'b0;
               end
            end
         end
      end else begin
         if (shadow_size == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.removed    = shadow_heap[0];
            shadow_heap[0] = shadow_heap[shadow_size-1];
            shadow_size--;
            // move the new root down; left child wins a tie, right only if present
            pos    = 0;
            moving = 1'b1;
            while (moving) begin
               lchild = 2 * pos + 1;
               rchild = 2 * pos + 2;
               if (lchild < shadow_size && shadow_heap[lchild] >= shadow_heap[pos] &&
                   (rchild >= shadow_size || shadow_heap[lchild] >= shadow_heap[rchild])) begin
                  tmp                 = shadow_heap[lchild];
                  shadow_heap[lchild] = shadow_heap[pos];
                  shadow_heap[pos]    = tmp;
                  pos                 = lchild;
               end else if (rchild < shadow_size && shadow_heap[rchild] >= shadow_heap[pos] &&
                            shadow_heap[rchild] >= shadow_heap[lchild]) begin
                  tmp                 = shadow_heap[rchild];
                  shadow_heap[rchild] = shadow_heap[pos];
                  shadow_heap[pos]    = tmp;
                  pos                 = rchild;
               end else begin
                  moving = 1'b0;
               end
            end
         end
      end
      res.count = COUNT_W'(shadow_size);
      res.top   = (shadow_size > 0) ? shadow_heap[0] : '0;
      return res;
   endfunction

   task automatic check_field(string field, logic signed [63:0] want_v, logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
         mismatch_tally++;
      end
   endtask

   // Results are compared before a new transaction is queued at the same edge
   always @(posedge clock) begin
      heap_result_type want;
      if (reset) begin
         shadow_size = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: result with no transaction outstanding, status %0d", $time,
                        rsp_status);
               mismatch_tally++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("removed_value", $signed(want.removed), rsp_removed_value);
               check_field("count", want.count, rsp_count);
               check_field("top_value", $signed(want.top), rsp_top_value);
            end
         end
         if (start && !busy) begin
            awaited_results.insert(awaited_results.size(),
                                   apply_heap_op(action_type'(req_action), req_value));
         end
      end
      error_count <= mismatch_tally;
      open_count  <= awaited_results.size();
   end

endmodule

[tb/sv/max_heap_priority_queue_top_tb.sv]
// Testbench top for the heap priority queue: clock, reset, stimulus and verdict.
module max_heap_priority_queue_top_tb;
   import mhpq_pkg::*;

   localparam int DUT_CAPACITY = DEF_CAPACITY;
   localparam int CYCLE_LIMIT  = 400000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_action = 1'b0;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_removed_value;
   logic [COUNT_W-1:0]         rsp_count;
   logic signed [DATA_W-1:0]   rsp_top_value;
   int                         error_count;
   int                         open_count;
   int                         cycle_count = 0;
   int                         heap_level = 0;
   bit                         no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   max_heap_priority_queue_top #(
      .CAPACITY (DUT_CAPACITY)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count),
      .rsp_top_value     (rsp_top_value)
   );

   max_heap_priority_queue_checker #(
      .CAPACITY (DUT_CAPACITY)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count),
      .rsp_top_value     (rsp_top_value),
      .error_count       (error_count),
      .open_count        (open_count)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Value mix: extremes, a narrow band that forces ties, and full-range noise
   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end else if (sel <= 4) begin
         return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      end
      return $signed($urandom());
   endfunction

   // One transaction: optional idle gap, then hold start until busy is low at an edge.
   // start stays high on back-to-back transactions so it never gets two updates per step.
   task automatic send_txn(action_type op, logic signed [DATA_W-1:0] val);
      int gap;
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= op;
      req_value  <= val;
      do @(posedge clock); while (busy);
      if (op == ACT_INSERT && heap_level < DUT_CAPACITY) heap_level++;
      if (op == ACT_REMOVE && heap_level > 0) heap_level--;
   endtask

   task automatic run_mix(int n_txn, int remove_pct);
      repeat (n_txn) begin
         send_txn(($urandom_range(0, 99) < remove_pct) ? ACT_REMOVE : ACT_INSERT, pick_value());
      end
   endtask

   // Hold off until every outstanding transaction has produced its result
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: remove on empty, extremes, ties at the root, then drain past empty
      send_txn(ACT_REMOVE, 32'sh7FFF_FFFF);
      send_txn(ACT_INSERT, 32'sh0000_0000);
      send_txn(ACT_INSERT, 32'sh7FFF_FFFF);
      send_txn(ACT_INSERT, 32'sh8000_0000);
      send_txn(ACT_INSERT, -32'sd1);
      send_txn(ACT_INSERT, 32'sh7FFF_FFFF);
      send_txn(ACT_INSERT, 32'sd5);
      send_txn(ACT_INSERT, 32'sd5);
      send_txn(ACT_INSERT, 32'shAAAA_AAAA);
      send_txn(ACT_INSERT, 32'sh5555_5555);
      repeat (9) send_txn(ACT_REMOVE, pick_value());
      send_txn(ACT_REMOVE, 32'sh8000_0000);
      wait_drained();

      // Random: shallow mix that keeps hitting empty
      run_mix(150, 50);
      wait_drained();

      // Fill to capacity with occasional removes
      while (heap_level < DUT_CAPACITY) begin
         send_txn(($urandom_range(0, 99) < 2) ? ACT_REMOVE : ACT_INSERT, pick_value());
      end

      // Around full: inserts bounce off the limit, removes sift through ten levels
      run_mix(150, 35);
      run_mix(150, 75);

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/mhpq_pkg.sv
sv/max_heap_priority_queue_top.sv
sv/mhpq_checker.sv
tb/sv/max_heap_priority_queue_checker.sv
tb/sv/max_heap_priority_queue_top_tb.sv
